FILE: rtl/button_matrix_debouncer_macros.svh
// assertion helpers shared by the debouncer
`ifndef BUTTON_MATRIX_DEBOUNCER_MACROS_SVH
`define BUTTON_MATRIX_DEBOUNCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_matrix_debouncer check failed");

// next-cycle implication, checked outside reset
`define BMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_matrix_debouncer check failed");

`endif

FILE: rtl/bmd_pkg.sv
package bmd_pkg;

  localparam int unsigned IndexWidth = 4;
  localparam int unsigned Slots      = 16;

  localparam logic [15:0] FORCE_MASK      = 16'hC000;
  localparam logic [15:0] PRESS_PATTERN   = 16'hE000;
  localparam logic [15:0] RELEASE_PATTERN = 16'hFFFF;

  localparam logic [1:0] EDGE_PRESS   = 2'b10;
  localparam logic [1:0] EDGE_RELEASE = 2'b01;

  typedef struct packed {
    logic [15:0] history;
    logic        held;
    logic [7:0]  queue;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{history: 16'hFFFF, held: 1'b0, queue: 8'h00};

  typedef struct packed {
    logic                  en;
    logic [IndexWidth-1:0] addr;
    entry_t                data;
  } mem_wr_t;

  // packed so that button_number lands in the low bits
  typedef struct packed {
    logic                  pad;
    logic [7:0]            edge_history;
    logic                  release_edge;
    logic                  press_edge;
    logic                  pressed;
    logic [IndexWidth-1:0] button_number;
  } result_t;

endpackage

FILE: rtl/bmd_state_mem.sv
module bmd_state_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [bmd_pkg::IndexWidth-1:0]    raddr,
  input  bmd_pkg::mem_wr_t                  wr,
  output bmd_pkg::entry_t                   rentry
);

  bmd_pkg::entry_t mem [bmd_pkg::Slots];
  bmd_pkg::entry_t rdata;
  bmd_pkg::entry_t fwd_data;
  logic [bmd_pkg::Slots-1:0] written;
  logic rd_written;
  logic fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata    <= mem[raddr];
      fwd_data <= wr.data;
    end
  end

  // valid bits stand in for the reset value of every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[raddr];
        fwd_hit    <= wr.en && (wr.addr == raddr);
      end
    end
  end

  // write in the read cycle to the same entry wins
  always_comb begin
    if (fwd_hit) begin
      rentry = fwd_data;
    end else if (rd_written) begin
      rentry = rdata;
    end else begin
      rentry = bmd_pkg::ENTRY_RESET;
    end
  end

endmodule

FILE: rtl/bmd_update.sv
module bmd_update #(
  parameter int unsigned ROWS    = 4,
  parameter int unsigned COLUMNS = 4
) (
  input  logic [bmd_pkg::IndexWidth-1:0] index,
  input  logic                           level,
  input  bmd_pkg::entry_t                cur,
  output logic                           in_range,
  output bmd_pkg::entry_t                next,
  output bmd_pkg::result_t               result
);

  localparam logic [8:0] Limit = 9'(ROWS * COLUMNS);

  logic [15:0] hist;
  logic rise, fall, held;

  always_comb begin
    in_range = {5'd0, index} < Limit;
    hist     = {cur.history[14:0], ~level} | bmd_pkg::FORCE_MASK;
    rise     = hist == bmd_pkg::PRESS_PATTERN;
    fall     = hist == bmd_pkg::RELEASE_PATTERN;
    held     = (rise || cur.held) && !fall;

    next.history = hist;
    next.held    = held;
    if (held != cur.held) begin
      next.queue = {cur.queue[5:0], held ? bmd_pkg::EDGE_PRESS : bmd_pkg::EDGE_RELEASE};
    end else begin
      next.queue = cur.queue;
    end

    result               = '0;
    result.button_number = index;
    if (in_range) begin
      result.pressed      = held;
      result.press_edge   = !cur.held && held;
      result.release_edge = cur.held && !held;
      result.edge_history = next.queue;
    end
  end

endmodule

FILE: rtl/button_matrix_debouncer.sv
// a sample passes the lookup stage and then the output register before its result
// shows on m_tvalid
// throughput: one sample per cycle while m_tready stays high, on any mix of button numbers
// the per-button state memory is read when a sample is accepted and written back when
// it leaves the lookup stage; a write to the entry in the cycle it is read is forwarded
// reset: synchronous, active high; every button reads as released with an
// all-ones history and an empty edge queue at once, no clearing pass
`include "button_matrix_debouncer_macros.svh"

module button_matrix_debouncer #(
  parameter int unsigned ROWS    = 4,
  parameter int unsigned COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] button_index, [4] contact_level, [7:5] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [3:0] button_number, [4] pressed, [5] press_edge,
                                 // [6] release_edge, [14:7] edge_history, [15] zero
);

  // lookup stage: item whose state entry is being read
  logic                           s1_valid;
  logic [bmd_pkg::IndexWidth-1:0] s1_index;
  logic                           s1_level;

  logic accept;
  logic advance;

  bmd_pkg::entry_t  cur_entry;
  bmd_pkg::entry_t  next_entry;
  bmd_pkg::result_t result;
  bmd_pkg::result_t out_data;
  bmd_pkg::mem_wr_t wr;
  logic             in_range;

  // lookup stage moves on when the output register is free or being drained
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index <= s_tdata[3:0];
      s1_level <= s_tdata[4];
    end
  end

  // write back only for positions inside the matrix
  always_comb begin
    wr.en   = advance && in_range;
    wr.addr = s1_index;
    wr.data = next_entry;
  end

  bmd_state_mem u_state_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .raddr  (s_tdata[3:0]),
    .wr     (wr),
    .rentry (cur_entry)
  );

  bmd_update #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_update (
    .index    (s1_index),
    .level    (s1_level),
    .cur      (cur_entry),
    .in_range (in_range),
    .next     (next_entry),
    .result   (result)
  );

  // output register, parts the result from the next lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tdata = out_data;

  `BMD_ASSERT_NOW(a_edges_exclusive, clk, rst, m_tvalid, !(out_data.press_edge && out_data.release_edge))
  `BMD_ASSERT_NOW(a_press_means_held, clk, rst, m_tvalid && out_data.press_edge, out_data.pressed)
  `BMD_ASSERT_NOW(a_release_means_open, clk, rst, m_tvalid && out_data.release_edge, !out_data.pressed)
  `BMD_ASSERT_NOW(a_stall_blocks_input, clk, rst, s1_valid && m_tvalid && !m_tready, !s_tready)
  `BMD_ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, m_tvalid)

endmodule
